// ===== rtl/wmpre_pkg.sv =====
// ----------------------------------------------------------------------------
// wmpre_pkg
// Shared types and constants of the wedge-masked pixel run encoder.
// ----------------------------------------------------------------------------
package wmpre_pkg;

  localparam int unsigned FRAME_WIDTH  = 480;
  localparam int unsigned FRAME_HEIGHT = 272;

  localparam int unsigned CoordW  = 9;
  localparam int unsigned TallyW  = 16;
  localparam int unsigned SlopeW  = 32;
  localparam int unsigned IcptW   = 48;
  localparam int unsigned ProdW   = CoordW + 1 + SlopeW;  // signed x times slope
  localparam int unsigned SumW    = 50;                   // edge test value, Q.16
  localparam int unsigned FracW   = 16;
  localparam int unsigned DataW   = 64;
  localparam int unsigned AddrW   = 6;

  localparam logic [TallyW-1:0] TallyMax = '1;

  typedef enum logic [2:0] {
    REG_SLOPE_FIRST      = 3'd0,
    REG_INTERCEPT_FIRST  = 3'd1,
    REG_SLOPE_SECOND     = 3'd2,
    REG_INTERCEPT_SECOND = 3'd3,
    REG_SIDE_MODE        = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic [SlopeW-1:0] slope_first;
    logic [IcptW-1:0]  intercept_first;
    logic [SlopeW-1:0] slope_second;
    logic [IcptW-1:0]  intercept_second;
    logic [1:0]        side_mode;
  } cfg_t;

  // Pixel position and frame markers carried along with each item.
  typedef struct packed {
    logic              pix;
    logic [CoordW-1:0] x;
    logic [CoordW-1:0] y;
    logic              row_end;
    logic              frame_last;
  } pix_t;

endpackage

// ===== rtl/wmpre_cfg.sv =====
// ----------------------------------------------------------------------------
// wmpre_cfg
// APB-style register file holding the two wedge edges and the side mode.
// ----------------------------------------------------------------------------
module wmpre_cfg import wmpre_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output cfg_t             cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[AddrW-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SLOPE_FIRST:      cfg_d.slope_first      = pwdata[SlopeW-1:0];
        REG_INTERCEPT_FIRST:  cfg_d.intercept_first  = pwdata[IcptW-1:0];
        REG_SLOPE_SECOND:     cfg_d.slope_second     = pwdata[SlopeW-1:0];
        REG_INTERCEPT_SECOND: cfg_d.intercept_second = pwdata[IcptW-1:0];
        REG_SIDE_MODE:        cfg_d.side_mode        = pwdata[1:0];
        default:              cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SLOPE_FIRST:      prdata = DataW'(cfg_q.slope_first);
      REG_INTERCEPT_FIRST:  prdata = DataW'(cfg_q.intercept_first);
      REG_SLOPE_SECOND:     prdata = DataW'(cfg_q.slope_second);
      REG_INTERCEPT_SECOND: prdata = DataW'(cfg_q.intercept_second);
      REG_SIDE_MODE:        prdata = DataW'(cfg_q.side_mode);
      default:              prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== rtl/wmpre_edge.sv =====
// ----------------------------------------------------------------------------
// wmpre_edge
// One half-plane test: registers x*slope and intercept-y, then compares the
// sum strictly against zero with optional inversion.
// ----------------------------------------------------------------------------
module wmpre_edge import wmpre_pkg::*; (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [CoordW-1:0] x_i,
  input  logic [CoordW-1:0] y_i,
  input  logic [SlopeW-1:0] slope_i,
  input  logic [IcptW-1:0]  intercept_i,
  input  logic              invert_i,
  output logic              pass_o
);

  logic signed [ProdW-1:0] prod_d;
  logic        [ProdW-1:0] prod_q;
  logic        [SumW-1:0]  base_d, base_q;
  logic        [SumW-1:0]  sum;

  assign prod_d = $signed({1'b0, x_i}) * $signed(slope_i);
  assign base_d = {{(SumW-IcptW){intercept_i[IcptW-1]}}, intercept_i}
                - {{(SumW-CoordW-FracW){1'b0}}, y_i, {FracW{1'b0}}};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      prod_q <= prod_d;
      base_q <= base_d;
    end
  end

  assign sum    = {{(SumW-ProdW){prod_q[ProdW-1]}}, prod_q} + base_q;
  assign pass_o = (!sum[SumW-1] && (sum != '0)) ^ invert_i;

endmodule

// ===== rtl/wmpre_tracker.sv =====
// ----------------------------------------------------------------------------
// wmpre_tracker
// Run tracker and result register: opens, extends and closes runs, keeps the
// frame's run tally and holds one result until it is taken.
// ----------------------------------------------------------------------------
module wmpre_tracker import wmpre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              item_valid_i,
  input  pix_t              item_i,
  input  logic              pass_first_i,
  input  logic              pass_second_i,
  output logic              take_o,
  output logic              result_valid_o,
  input  logic              result_ready_i,
  output logic              run_valid_o,
  output logic [CoordW-1:0] run_start_x_o,
  output logic [CoordW-1:0] run_row_o,
  output logic [CoordW-1:0] run_extra_o,
  output logic              frame_end_o,
  output logic [TallyW-1:0] runs_in_frame_o
);

  logic              open_q, open_d;
  logic [CoordW-1:0] start_q, start_d;
  logic [CoordW-1:0] extra_q, extra_d;
  logic [TallyW-1:0] tally_q, tally_d, tally_mid;
  logic              out_valid_q, out_valid_d;
  logic              run_valid_q, frame_end_q;
  logic [CoordW-1:0] start_out_q, row_out_q, extra_out_q;
  logic [TallyW-1:0] runs_out_q;

  logic qualify, emit, fire, load;

  assign take_o  = !out_valid_q || result_ready_i;
  assign fire    = item_valid_i && take_o;
  assign qualify = item_i.pix && pass_first_i && pass_second_i;
  // a run closes on a non-qualifying pixel, or at the row's last column
  assign emit    = (open_q && !qualify) || (item_i.row_end && qualify);
  assign load    = fire && (emit || item_i.frame_last);

  always_comb begin
    start_d = start_q;
    extra_d = extra_q;
    if (qualify) begin
      if (!open_q) begin
        start_d = item_i.x;
        extra_d = '0;
      end else begin
        extra_d = extra_q + CoordW'(1);
      end
    end
    open_d    = qualify && !item_i.row_end;
    tally_mid = (emit && tally_q != TallyMax) ? tally_q + TallyW'(1) : tally_q;
    tally_d   = item_i.frame_last ? '0 : tally_mid;
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (load) begin
      out_valid_d = 1'b1;
    end else if (result_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      open_q      <= 1'b0;
      start_q     <= '0;
      extra_q     <= '0;
      tally_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (fire) begin
        open_q  <= open_d;
        start_q <= start_d;
        extra_q <= extra_d;
        tally_q <= tally_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      run_valid_q <= emit;
      start_out_q <= emit ? start_d : '0;
      row_out_q   <= emit ? item_i.y : '0;
      extra_out_q <= emit ? extra_d : '0;
      frame_end_q <= item_i.frame_last;
      runs_out_q  <= tally_mid;
    end
  end

  assign result_valid_o  = out_valid_q;
  assign run_valid_o     = run_valid_q;
  assign run_start_x_o   = start_out_q;
  assign run_row_o       = row_out_q;
  assign run_extra_o     = extra_out_q;
  assign frame_end_o     = frame_end_q;
  assign runs_in_frame_o = runs_out_q;

`ifndef SYNTH
  a_result_has_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (run_valid_q || frame_end_q))
    else $error("result with neither run nor frame end");

  a_run_fits_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && run_valid_q) |->
      ((11'(start_out_q) + 11'(extra_out_q)) < 11'(FRAME_WIDTH)))
    else $error("run reaches past the row end");

  a_row_end_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item_i.row_end) |=> !open_q)
    else $error("run left open across a row end");

  a_frame_clears_tally: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && item_i.frame_last) |=> (tally_q == '0))
    else $error("run tally not cleared at frame end");
`endif

endmodule

// ===== rtl/wedge_masked_pixel_run_encoder_core.sv =====
// ----------------------------------------------------------------------------
// wedge_masked_pixel_run_encoder_core
// Raster pixel run encoder with a wedge mask of first and second edges and APB configuration.
// ----------------------------------------------------------------------------
// Pipeline: an accepted pixel passes the position register, the product register
//   and then the result register.
// Throughput: one pixel per cycle; the stages stall only on result backpressure.
// Reset: rst_ni clears the registers, position counters, run state and tally.
// ----------------------------------------------------------------------------
module wedge_masked_pixel_run_encoder_core import wmpre_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [AddrW-1:0]  paddr,
  input  logic [DataW-1:0]  pwdata,
  output logic [DataW-1:0]  prdata,
  output logic              pready,
  input  logic              pixel_valid_i,
  output logic              pixel_ready_o,
  input  logic              pixel_on_i,
  output logic              result_valid_o,
  input  logic              result_ready_i,
  output logic              run_valid_o,
  output logic [CoordW-1:0] run_start_x_o,
  output logic [CoordW-1:0] run_row_o,
  output logic [CoordW-1:0] run_extra_o,
  output logic              frame_end_o,
  output logic [TallyW-1:0] runs_in_frame_o
);

  cfg_t              cfg;
  logic [CoordW-1:0] col_q, col_d, row_q, row_d;
  logic              row_end, frame_last;
  pix_t              a_q, b_q;
  logic              a_valid_q, b_valid_q;
  logic              a_free, b_free, a_adv, b_adv, in_fire, take;
  logic              pass_first, pass_second;

  wmpre_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // handshake chain back from the result register
  assign b_free        = !b_valid_q || take;
  assign b_adv         = b_valid_q && take;
  assign a_free        = !a_valid_q || b_free;
  assign a_adv         = a_valid_q && b_free;
  assign pixel_ready_o = a_free;
  assign in_fire       = pixel_valid_i && a_free;

  assign row_end    = col_q >= CoordW'(FRAME_WIDTH - 1);
  assign frame_last = row_end && (row_q >= CoordW'(FRAME_HEIGHT - 1));

  always_comb begin
    col_d = col_q + CoordW'(1);
    row_d = row_q;
    if (row_end) begin
      col_d = '0;
      row_d = frame_last ? '0 : row_q + CoordW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (a_free) begin
        a_valid_q <= pixel_valid_i;
      end
      if (b_free) begin
        b_valid_q <= a_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      a_q <= '{pix: pixel_on_i, x: col_q, y: row_q, row_end: row_end,
               frame_last: frame_last};
    end
    if (a_adv) begin
      b_q <= a_q;
    end
  end

  wmpre_edge u_edge_first (
    .clk_i       (clk_i),
    .en_i        (a_adv),
    .x_i         (a_q.x),
    .y_i         (a_q.y),
    .slope_i     (cfg.slope_first),
    .intercept_i (cfg.intercept_first),
    .invert_i    (cfg.side_mode[0]),
    .pass_o      (pass_first)
  );

  wmpre_edge u_edge_second (
    .clk_i       (clk_i),
    .en_i        (a_adv),
    .x_i         (a_q.x),
    .y_i         (a_q.y),
    .slope_i     (cfg.slope_second),
    .intercept_i (cfg.intercept_second),
    .invert_i    (cfg.side_mode[1]),
    .pass_o      (pass_second)
  );

  wmpre_tracker u_tracker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .item_valid_i    (b_adv),
    .item_i          (b_q),
    .pass_first_i    (pass_first),
    .pass_second_i   (pass_second),
    .take_o          (take),
    .result_valid_o  (result_valid_o),
    .result_ready_i  (result_ready_i),
    .run_valid_o     (run_valid_o),
    .run_start_x_o   (run_start_x_o),
    .run_row_o       (run_row_o),
    .run_extra_o     (run_extra_o),
    .frame_end_o     (frame_end_o),
    .runs_in_frame_o (runs_in_frame_o)
  );

endmodule

// ===== sim/tb_wedge_masked_pixel_run_encoder_core.sv =====
// ----------------------------------------------------------------------------
// tb_wedge_masked_pixel_run_encoder_core
// Self-checking bench for the wedge-masked pixel run encoder. A short directed
// sequence checks the reset settings, single and multi pixel runs and the
// register extremes. Random settings and pixel densities then stream short
// stretches over the first rows and a tail. Every result is compared against a
// written-out expectation or a local run tracker that mirrors the registers.
// Both handshake sides idle at random.
// ----------------------------------------------------------------------------
module tb_wedge_masked_pixel_run_encoder_core;
  import wmpre_pkg::*;

  localparam int CycleLimit  = 200_000;
  localparam int DrainCycles = 8;
  localparam int HoldCycles  = 400;
  localparam int UnmappedIdx = 5;
  localparam int RandItems   = 850;
  localparam int TailItems   = 400;

  typedef struct packed {
    logic              run_valid;
    logic [CoordW-1:0] start_x;
    logic [CoordW-1:0] row;
    logic [CoordW-1:0] extra;
    logic              frame_end;
    logic [TallyW-1:0] tally;
  } run_rec_t;

  typedef enum logic {ROW_PIX, ROW_WR} row_kind_e;

  typedef struct packed {
    row_kind_e        kind;
    reg_idx_e         idx;
    logic [DataW-1:0] data;
    logic             pix;
    logic             typed;    // expectation written out below
    logic             has_run;
    run_rec_t         run;
  } step_row_t;

  localparam run_rec_t NoRun = '0;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [AddrW-1:0]  paddr = '0;
  logic [DataW-1:0]  pwdata = '0;
  logic [DataW-1:0]  prdata;
  logic              pready;
  logic              pixel_valid_i = 1'b0;
  logic              pixel_ready_o;
  logic              pixel_on_i = 1'b0;
  logic              result_valid_o;
  logic              result_ready_i = 1'b0;
  logic              run_valid_o;
  logic [CoordW-1:0] run_start_x_o;
  logic [CoordW-1:0] run_row_o;
  logic [CoordW-1:0] run_extra_o;
  logic              frame_end_o;
  logic [TallyW-1:0] runs_in_frame_o;

  wedge_masked_pixel_run_encoder_core uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .pixel_valid_i  (pixel_valid_i),
    .pixel_ready_o  (pixel_ready_o),
    .pixel_on_i     (pixel_on_i),
    .result_valid_o (result_valid_o),
    .result_ready_i (result_ready_i),
    .run_valid_o    (run_valid_o),
    .run_start_x_o  (run_start_x_o),
    .run_row_o      (run_row_o),
    .run_extra_o    (run_extra_o),
    .frame_end_o    (frame_end_o),
    .runs_in_frame_o(runs_in_frame_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Tracker state and register mirror
  cfg_t              wedge_cfg = '0;
  logic [CoordW-1:0] px_col = '0;
  logic [CoordW-1:0] px_row = '0;
  logic              run_is_open = 1'b0;
  logic [CoordW-1:0] run_start = '0;
  logic [CoordW-1:0] run_len_m1 = '0;
  logic [TallyW-1:0] frame_runs = '0;

  run_rec_t pending_runs [$];

  int  mismatches = 0;
  int  results_seen = 0;
  int  runs_seen = 0;
  int  frame_ends_seen = 0;
  int  items_sent = 0;
  int  settings_used = 0;
  bit  calm = 1'b1;
  bit  hold_req = 1'b0;
  bit  hold_taken = 1'b0;

  step_row_t dir_rows [0:25] = '{
    // reset settings: nothing qualifies
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b1, 1'b1, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b1, 1'b1, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b0, 1'b1, 1'b0, NoRun},
    // both tests inverted with zero edges: every set pixel qualifies; junk above width
    '{ROW_WR, REG_SIDE_MODE, 64'hDEAD_BEEF_0000_0003, 1'b0, 1'b0, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b1, 1'b1, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b0, 1'b1, 1'b1,
      '{1'b1, 9'd3, 9'd0, 9'd0, 1'b0, 16'd1}},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b1, 1'b1, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b1, 1'b1, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b1, 1'b1, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b0, 1'b1, 1'b1,
      '{1'b1, 9'd5, 9'd0, 9'd2, 1'b0, 16'd2}},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b0, 1'b1, 1'b0, NoRun},
    '{ROW_WR, REG_SIDE_MODE, 64'd0, 1'b0, 1'b0, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b1, 1'b1, 1'b0, NoRun},
    // slope and intercept extremes
    '{ROW_WR, REG_SLOPE_FIRST, 64'h0000_0000_7FFF_FFFF, 1'b0, 1'b0, 1'b0, NoRun},
    '{ROW_WR, REG_SIDE_MODE, 64'd2, 1'b0, 1'b0, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b1, 1'b0, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b0, 1'b0, 1'b0, NoRun},
    '{ROW_WR, REG_INTERCEPT_FIRST, 64'h0000_8000_0000_0000, 1'b0, 1'b0, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b1, 1'b0, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b0, 1'b0, 1'b0, NoRun},
    '{ROW_WR, REG_SLOPE_SECOND, 64'hFFFF_FFFF_8000_0000, 1'b0, 1'b0, 1'b0, NoRun},
    '{ROW_WR, REG_INTERCEPT_SECOND, 64'h0000_7FFF_FFFF_FFFF, 1'b0, 1'b0, 1'b0, NoRun},
    '{ROW_WR, REG_SIDE_MODE, 64'd1, 1'b0, 1'b0, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b1, 1'b0, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b1, 1'b0, 1'b0, NoRun},
    '{ROW_PIX, REG_SIDE_MODE, 64'd0, 1'b0, 1'b0, 1'b0, NoRun}
  };

  // x*slope + intercept - y in Q.16, strict compare, optional inversion
  function automatic bit edge_pass(logic [SlopeW-1:0] slope, logic [IcptW-1:0] icpt,
                                   logic [CoordW-1:0] x, logic [CoordW-1:0] y,
                                   logic invert);
    longint v;
    v = longint'(x) * longint'($signed(slope)) + longint'($signed(icpt))
        - longint'(y) * 65536;
    return (v > 0) != invert;
  endfunction

  function automatic void encode_pixel(input logic pix, output bit has, output run_rec_t rec);
    logic row_end;
    logic frame_last;
    logic qualifies;
    logic emit;
    row_end    = (px_col >= CoordW'(FRAME_WIDTH - 1));
    frame_last = row_end && (px_row >= CoordW'(FRAME_HEIGHT - 1));
    qualifies = pix
      && edge_pass(wedge_cfg.slope_first, wedge_cfg.intercept_first, px_col, px_row,
                   wedge_cfg.side_mode[0])
      && edge_pass(wedge_cfg.slope_second, wedge_cfg.intercept_second, px_col, px_row,
                   wedge_cfg.side_mode[1]);
    emit = 1'b0;
    if (qualifies) begin
      if (!run_is_open) begin
        run_is_open = 1'b1;
        run_start   = px_col;
        run_len_m1  = '0;
      end else begin
        run_len_m1 = run_len_m1 + 1'b1;
      end
    end else if (run_is_open) begin
      emit = 1'b1;
      run_is_open = 1'b0;
    end
    if (row_end && run_is_open) begin
      emit = 1'b1;
      run_is_open = 1'b0;
    end
    rec = '0;
    if (emit) begin
      rec.run_valid = 1'b1;
      rec.start_x   = run_start;
      rec.row       = px_row;
      rec.extra     = run_len_m1;
      if (frame_runs != TallyMax) frame_runs = frame_runs + 1'b1;
    end
    rec.frame_end = frame_last;
    rec.tally     = frame_runs;
    has = emit || frame_last;
    if (row_end) begin
      px_col = '0;
      if (frame_last) begin
        px_row = '0;
        frame_runs = '0;
      end else begin
        px_row = px_row + 1'b1;
      end
    end else begin
      px_col = px_col + 1'b1;
    end
  endfunction

  // setup, access, then idle with psel low so back-to-back writes never collide
  task automatic apb_write(input logic [AddrW-1:0] addr, input logic [DataW-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [DataW-1:0] data);
    apb_write(AddrW'(8 * int'(idx)), data);
    case (idx)
      REG_SLOPE_FIRST:      wedge_cfg.slope_first      = data[SlopeW-1:0];
      REG_INTERCEPT_FIRST:  wedge_cfg.intercept_first  = data[IcptW-1:0];
      REG_SLOPE_SECOND:     wedge_cfg.slope_second     = data[SlopeW-1:0];
      REG_INTERCEPT_SECOND: wedge_cfg.intercept_second = data[IcptW-1:0];
      REG_SIDE_MODE:        wedge_cfg.side_mode        = data[1:0];
      default: ;
    endcase
  endtask

  function automatic logic [SlopeW-1:0] wedge_slope();
    int k;
    if ($urandom_range(0, 2) == 0) k = (int'($urandom_range(0, 4)) - 2) * 65536;
    else k = int'($urandom_range(0, 262144)) - 131072;
    return SlopeW'(k);
  endfunction

  function automatic logic [IcptW-1:0] wedge_icpt();
    longint b;
    b = longint'(int'($urandom_range(0, 800)) - 300) * 65536;
    if ($urandom_range(0, 1) == 1) b = b + $urandom_range(0, 65535);
    return IcptW'(b);
  endfunction

  function automatic logic [SlopeW-1:0] wild_slope();
    case ($urandom_range(0, 3))
      0:       return 32'h8000_0000;
      1:       return 32'h7FFF_FFFF;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [IcptW-1:0] wild_icpt();
    case ($urandom_range(0, 3))
      0:       return 48'h8000_0000_0000;
      1:       return 48'h7FFF_FFFF_FFFF;
      default: return IcptW'({$urandom, $urandom});
    endcase
  endfunction

  // all_pass: zero edges with both tests inverted, every set pixel qualifies
  task automatic load_settings(input bit all_pass);
    logic [SlopeW-1:0] s1, s2;
    logic [IcptW-1:0]  b1, b2;
    logic [1:0]        side;
    int                kind;
    kind = all_pass ? 0 : int'($urandom_range(1, 20));
    if (kind == 0) begin
      s1 = '0; s2 = '0; b1 = '0; b2 = '0; side = 2'b11;
    end else if (kind <= 14) begin
      s1 = wedge_slope(); s2 = wedge_slope();
      b1 = wedge_icpt();  b2 = wedge_icpt();
      side = 2'($urandom_range(0, 3));
    end else begin
      s1 = wild_slope(); s2 = wild_slope();
      b1 = wild_icpt();  b2 = wild_icpt();
      side = 2'($urandom_range(0, 3));
    end
    if ($urandom_range(0, 3) == 0)
      apb_write(AddrW'(8 * int'($urandom_range(UnmappedIdx, 7))), {$urandom, $urandom});
    write_reg(REG_SLOPE_FIRST, {$urandom, s1});
    write_reg(REG_INTERCEPT_FIRST, {16'($urandom), b1});
    write_reg(REG_SLOPE_SECOND, {$urandom, s2});
    write_reg(REG_INTERCEPT_SECOND, {16'($urandom), b2});
    write_reg(REG_SIDE_MODE, {$urandom, 30'($urandom), side});
    settings_used++;
  endtask

  task automatic offer_pixel(input logic pix, input logic typed, input logic typed_has,
                             input run_rec_t typed_run);
    bit       has;
    run_rec_t rec;
    pixel_valid_i <= 1'b1;
    pixel_on_i    <= pix;
    do @(posedge clk_i); while (!pixel_ready_o);
    encode_pixel(pix, has, rec);
    if (typed) begin
      if (typed_has) pending_runs.push_back(typed_run);
    end else if (has) begin
      pending_runs.push_back(rec);
    end
    items_sent++;
  endtask

  // pixels that yield nothing may still be in flight when the queue empties
  task automatic wait_drained();
    pixel_valid_i <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // result side: random stalls plus one long hold-off on request
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(posedge clk_i);
      if (stall > 0) begin
        result_ready_i <= 1'b0;
        stall--;
      end else if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        stall = HoldCycles - 1;
        result_ready_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 15) == 0) begin
        stall = int'($urandom_range(0, 17));
        result_ready_i <= 1'b0;
      end else begin
        result_ready_i <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    run_rec_t got;
    run_rec_t want;
    if (rst_ni && result_valid_o && result_ready_i) begin
      got = {run_valid_o, run_start_x_o, run_row_o, run_extra_o, frame_end_o,
             runs_in_frame_o};
      results_seen++;
      if (got.run_valid) runs_seen++;
      if (got.frame_end) frame_ends_seen++;
      if (pending_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: unexpected result valid=%0b x=%0d row=%0d extra=%0d end=%0b runs=%0d",
                   got.run_valid, got.start_x, got.row, got.extra, got.frame_end, got.tally);
      end else begin
        want = pending_runs.pop_front();
        if (got.run_valid !== want.run_valid || got.start_x !== want.start_x ||
            got.row !== want.row || got.extra !== want.extra ||
            got.frame_end !== want.frame_end || got.tally !== want.tally) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch: expected valid=%0b x=%0d row=%0d extra=%0d end=%0b runs=%0d",
                     want.run_valid, want.start_x, want.row, want.extra, want.frame_end,
                     want.tally);
            $display("          actual   valid=%0b x=%0d row=%0d extra=%0d end=%0b runs=%0d",
                     got.run_valid, got.start_x, got.row, got.extra, got.frame_end, got.tally);
          end
        end
      end
    end
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d results outstanding", cycles, pending_runs.size());
    $display("wedge_masked_pixel_run_encoder_core test failed");
    $finish;
  end

  initial begin
    int   phase;
    int   len;
    int   dens;
    logic pix;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_WR) begin
        wait_drained();
        write_reg(dir_rows[i].idx, dir_rows[i].data);
      end else begin
        offer_pixel(dir_rows[i].pix, dir_rows[i].typed, dir_rows[i].has_run, dir_rows[i].run);
      end
    end

    // random settings per stretch, but the fourth stretch uses the all-pass settings and runs dense under the long hold
    phase = 0;
    while (items_sent < RandItems) begin
      wait_drained();
      len = int'($urandom_range(60, 160));
      load_settings(phase == 3);
      calm = (phase % 6 == 4);
      if (phase == 3) hold_req = 1'b1;
      dens = (phase == 3) ? 12 : int'($urandom_range(0, 16));
      for (int i = 0; i < len; i++) begin
        pix = (int'($urandom_range(0, 15)) < dens);
        offer_pixel(pix, 1'b0, 1'b0, NoRun);
        if (!calm && $urandom_range(0, 23) == 0) begin
          pixel_valid_i <= 1'b0;
          repeat ($urandom_range(1, 18)) @(posedge clk_i);
        end
      end
      phase++;
    end

    wait_drained();
    load_settings(1'b0);
    calm = 1'b1;
    for (int i = 0; i < TailItems; i++)
      offer_pixel(1'($urandom_range(0, 1)), 1'b0, 1'b0, NoRun);
    wait_drained();

    $display("covered %0d pixels over the first rows under %0d register settings",
             items_sent, settings_used);
    $display("checked %0d results: %0d runs, %0d frame ends, %0d mismatches",
             results_seen, runs_seen, frame_ends_seen, mismatches);
    if (mismatches == 0) begin
      $display("wedge_masked_pixel_run_encoder_core test passed");
    end else begin
      $display("wedge_masked_pixel_run_encoder_core test failed");
    end
    $finish;
  end

endmodule
